### hw/rtl/csscan_pkg.sv
// ----------------------------------------------------------------------------
// csscan_pkg
// Shared types and constants of the config syntax scanner: byte classes,
// scanner modes, token kinds, verdict codes and the queue entry format.
// ----------------------------------------------------------------------------
package csscan_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_OPEN   = 8'h7B;  // {
  localparam logic [7:0] CH_CLOSE  = 8'h7D;  // }
  localparam logic [7:0] CH_HASH   = 8'h23;  // #
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // "
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // '
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_BREAK,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_SEMI,
    CLS_HASH,
    CLS_QUOTE,
    CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_WORD    = 2'd2,
    MODE_BREAK   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_WORD  = 3'd1,
    KIND_OPEN  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_SEMI  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_RUN    = 2'd0,
    VERDICT_ACCEPT = 2'd1,
    VERDICT_REJECT = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    PUNCT_NONE  = 2'd0,
    PUNCT_OPEN  = 2'd1,
    PUNCT_CLOSE = 2'd2,
    PUNCT_SEMI  = 2'd3
  } punct_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    cls_t       cls;
  } cls_item_t;

endpackage

### hw/rtl/csscan_if.sv
// ----------------------------------------------------------------------------
// csscan_if
// Valid/ready channels of the config syntax scanner: text bytes in,
// per-byte scan results out.
// ----------------------------------------------------------------------------
interface csscan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface csscan_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       word_byte;
  logic       new_statement;
  logic       word_done;
  logic [1:0] punct;
  logic [7:0] depth;
  logic [1:0] status;

  modport source (
    output valid, output byte_out, output word_byte, output new_statement,
    output word_done, output punct, output depth, output status,
    input ready
  );
  modport sink (
    input valid, input byte_out, input word_byte, input new_statement,
    input word_done, input punct, input depth, input status,
    output ready
  );
endinterface

### hw/rtl/csscan_front.sv
// ----------------------------------------------------------------------------
// csscan_front
// Accepts text items and sorts each byte into a class for the back end.
// ----------------------------------------------------------------------------
module csscan_front (
  csscan_in_if.sink               in_bus,
  input  logic                    q_ready,
  output logic                    q_push,
  output csscan_pkg::cls_item_t   q_item
);
  import csscan_pkg::*;

  cls_t cls;

  always_comb begin
    case (in_bus.ch)
      CH_SPACE, CH_TAB:     cls = CLS_BLANK;
      CH_LF, CH_CR:         cls = CLS_BREAK;
      CH_OPEN:              cls = CLS_OPEN;
      CH_CLOSE:             cls = CLS_CLOSE;
      CH_SEMI:              cls = CLS_SEMI;
      CH_HASH:              cls = CLS_HASH;
      CH_DQUOTE, CH_SQUOTE: cls = CLS_QUOTE;
      default:              cls = CLS_OTHER;
    endcase
  end

  assign in_bus.ready = q_ready;
  assign q_push       = in_bus.valid & q_ready;
  // Echo 0 for the end marker.
  assign q_item       = {(in_bus.end_of_input ? 8'h00 : in_bus.ch), in_bus.end_of_input, cls};

endmodule

### hw/rtl/csscan_queue.sv
// ----------------------------------------------------------------------------
// csscan_queue
// Short FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
module csscan_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  csscan_pkg::cls_item_t   push_item,
  output logic                    push_ready,
  input  logic                    pop,
  output logic                    pop_valid,
  output csscan_pkg::cls_item_t   pop_item
);
  import csscan_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_item_t               mem_r [QUEUE_DEPTH];
  logic      [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic      [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic      [CNT_W-1:0]   count_r, count_nxt;
  logic                    do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_pop     = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/csscan_back.sv
// ----------------------------------------------------------------------------
// csscan_back
// Scanner state machine and syntax rules; registers one result per item.
// ----------------------------------------------------------------------------
module csscan_back #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  csscan_pkg::cls_item_t   q_item,
  output logic                    q_pop,
  csscan_out_if.source            out_bus
);
  import csscan_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH);

  mode_t          mode_r, mode_nxt;
  kind_t          kind_r, kind_nxt;
  logic [DW-1:0]  depth_r, depth_nxt;
  verdict_t       verdict_r, verdict_nxt;

  logic           out_valid_r;
  logic [7:0]     byte_r;
  logic           word_r, word_nxt;
  logic           new_r, new_nxt;
  logic           done_r, done_nxt;
  punct_t         punct_r, punct_nxt;
  logic [DW+7:0]  depth_ext;

  logic           take;

  assign take  = q_valid & (~out_valid_r | out_bus.ready);
  assign q_pop = take;

  always_comb begin
    logic  do_start;
    kind_t eff_kind;

    mode_nxt    = mode_r;
    kind_nxt    = kind_r;
    depth_nxt   = depth_r;
    verdict_nxt = verdict_r;
    word_nxt    = 1'b0;
    new_nxt     = 1'b0;
    done_nxt    = 1'b0;
    punct_nxt   = PUNCT_NONE;
    do_start    = 1'b0;
    eff_kind    = kind_r;

    if (verdict_r == VERDICT_RUN) begin
      if (q_item.eoi) begin
        if (mode_r == MODE_WORD) begin
          verdict_nxt = VERDICT_REJECT;
        end else if ((kind_r == KIND_SEMI || kind_r == KIND_CLOSE) && depth_r == '0) begin
          verdict_nxt = VERDICT_ACCEPT;
        end else begin
          verdict_nxt = VERDICT_REJECT;
        end
      end else begin
        case (mode_r)
          MODE_COMMENT: begin
            if (q_item.cls == CLS_BREAK) begin
              mode_nxt = MODE_START;
            end
          end
          MODE_WORD: begin
            if (q_item.cls == CLS_BLANK || q_item.cls == CLS_BREAK ||
                q_item.cls == CLS_SEMI || q_item.cls == CLS_OPEN ||
                q_item.cls == CLS_CLOSE) begin
              done_nxt = 1'b1;
              kind_nxt = KIND_WORD;
              eff_kind = KIND_WORD;
              mode_nxt = MODE_START;
              do_start = 1'b1;
            end else begin
              word_nxt = 1'b1;
            end
          end
          MODE_BREAK: begin
            if (q_item.cls != CLS_BLANK && q_item.cls != CLS_BREAK) begin
              if (kind_r == KIND_WORD) begin
                // line break inside a statement
                verdict_nxt = VERDICT_REJECT;
              end else begin
                mode_nxt = MODE_START;
                do_start = 1'b1;
              end
            end
          end
          default: begin
            do_start = 1'b1;
          end
        endcase

        if (do_start) begin
          case (q_item.cls)
            CLS_OPEN: begin
              if (eff_kind != KIND_WORD || depth_r >= DEPTH_LIMIT) begin
                verdict_nxt = VERDICT_REJECT;
              end else begin
                depth_nxt = depth_r + 1'b1;
                kind_nxt  = KIND_OPEN;
                punct_nxt = PUNCT_OPEN;
              end
            end
            CLS_CLOSE: begin
              if ((eff_kind != KIND_SEMI && eff_kind != KIND_OPEN &&
                   eff_kind != KIND_CLOSE) || depth_r == '0) begin
                verdict_nxt = VERDICT_REJECT;
              end else begin
                depth_nxt = depth_r - 1'b1;
                kind_nxt  = KIND_CLOSE;
                punct_nxt = PUNCT_CLOSE;
              end
            end
            CLS_SEMI: begin
              if (eff_kind != KIND_WORD) begin
                verdict_nxt = VERDICT_REJECT;
              end else begin
                kind_nxt  = KIND_SEMI;
                punct_nxt = PUNCT_SEMI;
              end
            end
            CLS_HASH:  mode_nxt = MODE_COMMENT;
            CLS_QUOTE: verdict_nxt = VERDICT_REJECT;
            CLS_BLANK: ;
            CLS_BREAK: mode_nxt = MODE_BREAK;
            default: begin
              word_nxt = 1'b1;
              new_nxt  = (eff_kind != KIND_WORD);
              mode_nxt = MODE_WORD;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_START;
      kind_r      <= KIND_START;
      depth_r     <= '0;
      verdict_r   <= VERDICT_RUN;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        mode_r    <= mode_nxt;
        kind_r    <= kind_nxt;
        depth_r   <= depth_nxt;
        verdict_r <= verdict_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r  <= q_item.ch;
      word_r  <= word_nxt;
      new_r   <= new_nxt;
      done_r  <= done_nxt;
      punct_r <= punct_nxt;
    end
  end

  // Depth and status come from the state registers, which advance with the result.
  assign depth_ext             = {8'h00, depth_r};
  assign out_bus.valid         = out_valid_r;
  assign out_bus.byte_out      = byte_r;
  assign out_bus.word_byte     = word_r;
  assign out_bus.new_statement = new_r;
  assign out_bus.word_done     = done_r;
  assign out_bus.punct         = punct_r;
  assign out_bus.depth         = depth_ext[7:0];
  assign out_bus.status        = verdict_r;

endmodule

### hw/rtl/config_syntax_scanner.sv
// ----------------------------------------------------------------------------
// config_syntax_scanner
// Streaming lexer and syntax checker for brace-structured config text.
// ----------------------------------------------------------------------------
// Feed the text one byte per item on in_bus, then one item with end_of_input
// set. Every item yields exactly one result on out_bus: the byte echoed (0 for
// the end marker), flags for word bytes, statement starts and word ends, the
// punctuation taken, the brace depth (low 8 bits) and a sticky status of
// running, accepted or rejected. Once decided, the state holds and later items
// only echo. The block sustains one item per clock while out_bus is ready: the
// front end classifies each byte as it is accepted and writes it into a
// four-entry queue, and the back end applies the scanner state update
// combinationally and holds the result in an output register, so either side
// may stall on its own. An accepted item passes through the queue before its
// result is registered in the back end and turns valid on out_bus.
// MAX_DEPTH (1..65535) sets the deepest brace nesting allowed.
// ----------------------------------------------------------------------------
module config_syntax_scanner #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic          clk,
  input  logic          rst_n,
  csscan_in_if.sink     in_bus,
  csscan_out_if.source  out_bus
);
  import csscan_pkg::*;

  // Front end to queue
  logic       push;
  logic       push_ready;
  cls_item_t  push_item;

  // Queue to back end
  logic       pop;
  logic       pop_valid;
  cls_item_t  pop_item;

  // Classify each accepted byte; accept whenever the queue has room.
  csscan_front u_front (
    .in_bus  (in_bus),
    .q_ready (push_ready),
    .q_push  (push),
    .q_item  (push_item)
  );

  // Hold classified items until the back end takes them.
  csscan_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  // Advance the scanner state and register the result.
  csscan_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_item  (pop_item),
    .q_pop   (pop),
    .out_bus (out_bus)
  );

endmodule
